[rtl/mecanum_wheel_command_framer_defines.svh]
// ----------------------------------------------------------------------------
// Mecanum wheel command framer assertion macros
// Shared property shapes for the concurrent checks of the framer.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_COMMAND_FRAMER_DEFINES_SVH
`define MECANUM_WHEEL_COMMAND_FRAMER_DEFINES_SVH

// same-cycle implication, checked outside of reset
`define MWCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside of reset
`define MWCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mwcf_pkg.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel command framer package
// Widths, codes, reset values and shared types of the framer.
// ----------------------------------------------------------------------------
package mwcf_pkg;

  // field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned VEL_W      = 16;
  localparam int unsigned TGT_W      = 20;
  localparam int unsigned WHEEL_W    = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned DIST_W     = 15;
  localparam int unsigned MAX_RPM_W  = 10;
  localparam int unsigned RPM_W      = 16;

  // frame layout
  localparam int unsigned FRAME_BYTES = 7;
  localparam int unsigned WHEELS      = 4;
  localparam int unsigned BIDX_W      = 3;

  // serial multiplier operand widths
  localparam int unsigned MUL_A_W = 20;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // fixed point scaling
  localparam int unsigned TWIST_SHIFT = 13;
  localparam int unsigned RPM_SHIFT   = 12;
  localparam int unsigned RPM_MAG_W   = MUL_P_W - RPM_SHIFT;

  localparam logic [RPM_W-1:0] RPM_POS_MAX = 16'h7FFF;
  localparam logic [RPM_W-1:0] RPM_NEG_MIN = 16'h8000;

  // crc-8/maxim, reflected
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TWIST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;

  // wheel order
  localparam logic [WHEEL_W-1:0] WHEEL_FL = 2'd0;
  localparam logic [WHEEL_W-1:0] WHEEL_FR = 2'd1;
  localparam logic [WHEEL_W-1:0] WHEEL_RL = 2'd2;
  localparam logic [WHEEL_W-1:0] WHEEL_RR = 2'd3;

  // byte positions within a frame
  localparam logic [BIDX_W-1:0] BYTE_ID     = 3'd0;
  localparam logic [BIDX_W-1:0] BYTE_OPCODE = 3'd1;
  localparam logic [BIDX_W-1:0] BYTE_RPM_LO = 3'd2;
  localparam logic [BIDX_W-1:0] BYTE_RPM_HI = 3'd3;
  localparam logic [BIDX_W-1:0] BYTE_CRC    = BIDX_W'(FRAME_BYTES - 1);
  localparam logic [BYTE_W-1:0] BYTE_PAD    = 8'h00;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_BASE  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRACK_WIDTH = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RPM     = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FL_ID       = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FR_ID       = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RL_ID       = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RR_ID       = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_OPCODE      = 4'd7;

  // register reset values
  localparam logic [DIST_W-1:0]    RST_WHEEL_BASE  = 15'd1229;
  localparam logic [DIST_W-1:0]    RST_TRACK_WIDTH = 15'd1229;
  localparam logic [MAX_RPM_W-1:0] RST_MAX_RPM     = 10'd200;
  localparam logic [BYTE_W-1:0]    RST_FL_ID       = 8'd1;
  localparam logic [BYTE_W-1:0]    RST_FR_ID       = 8'd2;
  localparam logic [BYTE_W-1:0]    RST_RL_ID       = 8'd3;
  localparam logic [BYTE_W-1:0]    RST_RR_ID       = 8'd4;
  localparam logic [BYTE_W-1:0]    RST_OPCODE      = 8'd0;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TWIST_MUL,
    S_RPM_START,
    S_RPM_MUL,
    S_BYTE,
    S_CRC
  } state_e;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // crc engine control
  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctrl_t;

endpackage

[rtl/mwcf_intf.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel command framer channels
// Valid/ready channels for commands, configuration writes and frame bytes.
// ----------------------------------------------------------------------------

// command channel
interface mwcf_in_if import mwcf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] yaw_rate;
  logic [WHEEL_W-1:0]      wheel_sel;
  logic signed [TGT_W-1:0] wheel_value;

  modport source (
    output valid, cmd, vel_x, vel_y, yaw_rate, wheel_sel, wheel_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, vel_x, vel_y, yaw_rate, wheel_sel, wheel_value,
    output ready
  );
endinterface

// configuration write channel
interface mwcf_cfg_if import mwcf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// frame byte channel
interface mwcf_out_if import mwcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  frame_byte;
  logic [WHEEL_W-1:0] wheel_index;
  logic               last;

  modport source (output valid, frame_byte, wheel_index, last, input ready);
  modport sink (input valid, frame_byte, wheel_index, last, output ready);
endinterface

[rtl/mwcf_sermul.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel command framer serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mwcf_sermul import mwcf_pkg::*; #(
  parameter int unsigned A_W = MUL_A_W,
  parameter int unsigned B_W = MUL_B_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output unit_stat_t         stat_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]     a_q;
  logic [A_W+B_W-1:0] p_q;
  logic [A_W:0]       sum;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;

  // partial sum on the upper A_W bits of the product register
  assign sum = {1'b0, p_q[A_W+B_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and product shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[B_W-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = p_q;

endmodule

[rtl/mwcf_crc8.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel command framer crc engine
// Bit-serial reflected crc-8, one data bit per cycle, lsb first.
// ----------------------------------------------------------------------------
module mwcf_crc8 import mwcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crc_ctrl_t         ctrl_i,
  input  logic [BYTE_W-1:0] data_i,
  output unit_stat_t        stat_o,
  output logic [BYTE_W-1:0] crc_o
);

  logic [BYTE_W-1:0] crc_q;
  logic [BYTE_W-1:0] data_q;
  logic [BIDX_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              fb;

  // feedback bit of the reflected lfsr
  assign fb = crc_q[0] ^ data_q[0];

  // lfsr and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.clear) begin
        crc_q <= CRC_INIT;
      end else if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= BIDX_W'(BYTE_W - 1);
      end else if (busy_q) begin
        crc_q <= {1'b0, crc_q[BYTE_W-1:1]} ^ (fb ? CRC_POLY : '0);
        cnt_q <= cnt_q - BIDX_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // data shift register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      data_q <= data_i;
    end else if (busy_q) begin
      data_q <= {1'b0, data_q[BYTE_W-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign crc_o       = crc_q;

endmodule

[rtl/mecanum_wheel_command_framer.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel command framer
// Mecanum inverse kinematics into a wheel target store, and motor velocity
// frames with crc-8/maxim sent out one byte per transfer.
// ----------------------------------------------------------------------------
// A wheel target write is stored straight from the idle state; a twist update
// waits on the bit-serial 16-step multiplier. A send tick gives 28 byte
// transfers: per wheel one 16-step multiply for the rpm, then each of the six
// covered bytes runs through the bit-serial crc before the next byte is
// handed off. A new command is taken once the previous one has finished its
// work; the last byte of a burst may still wait in the output register at that
// point.
`include "mecanum_wheel_command_framer_defines.svh"

module mecanum_wheel_command_framer import mwcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mwcf_in_if.sink    in_i,
  mwcf_cfg_if.sink   cfg_i,
  mwcf_out_if.source out_o
);

  // configuration registers
  logic [DIST_W-1:0]    wheel_base_q;
  logic [DIST_W-1:0]    track_width_q;
  logic [MAX_RPM_W-1:0] max_rpm_q;
  logic [BYTE_W-1:0]    motor_id_q [WHEELS];
  logic [BYTE_W-1:0]    opcode_q;

  // wheel target store
  logic signed [TGT_W-1:0] targets_q [WHEELS];

  // sequencer
  state_e             state_q, state_d;
  logic [WHEEL_W-1:0] wheel_q, wheel_d;
  logic [BIDX_W-1:0]  byte_idx_q, byte_idx_d;
  logic               neg_q, neg_d;
  logic               in_ready;
  logic               twist_wr;
  logic               set_wr;
  logic               rpm_load;
  logic               out_load;

  // twist operands held through the multiply
  logic signed [VEL_W-1:0] vel_x_q;
  logic signed [VEL_W-1:0] vel_y_q;

  // multiplier and crc hookup
  logic                 mul_start;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_prod;
  unit_stat_t           mul_stat;
  crc_ctrl_t            crc_ctrl;
  unit_stat_t           crc_stat;
  logic [BYTE_W-1:0]    crc_value;

  // datapath
  logic [VEL_W-1:0]        abs_wz;
  logic signed [TGT_W-1:0] cur_tgt;
  logic [TGT_W-1:0]        abs_tgt;
  logic [TGT_W-1:0]        w_mag;
  logic signed [TGT_W-1:0] w_val;
  logic signed [TGT_W-1:0] vx_ext;
  logic signed [TGT_W-1:0] vy_ext;
  logic [RPM_MAG_W-1:0]    rpm_mag;
  logic [RPM_W-1:0]        rpm_sat;
  logic [RPM_W-1:0]        rpm_q;
  logic [BYTE_W-1:0]       cur_byte;

  // output register
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic [WHEEL_W-1:0] out_wheel_q;
  logic               out_last_q;
  logic               out_free;

  // configuration writes, indexes beyond the list are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_base_q          <= RST_WHEEL_BASE;
      track_width_q         <= RST_TRACK_WIDTH;
      max_rpm_q             <= RST_MAX_RPM;
      motor_id_q[WHEEL_FL]  <= RST_FL_ID;
      motor_id_q[WHEEL_FR]  <= RST_FR_ID;
      motor_id_q[WHEEL_RL]  <= RST_RL_ID;
      motor_id_q[WHEEL_RR]  <= RST_RR_ID;
      opcode_q              <= RST_OPCODE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        REG_WHEEL_BASE:  wheel_base_q         <= cfg_i.data[DIST_W-1:0];
        REG_TRACK_WIDTH: track_width_q        <= cfg_i.data[DIST_W-1:0];
        REG_MAX_RPM:     max_rpm_q            <= cfg_i.data[MAX_RPM_W-1:0];
        REG_FL_ID:       motor_id_q[WHEEL_FL] <= cfg_i.data[BYTE_W-1:0];
        REG_FR_ID:       motor_id_q[WHEEL_FR] <= cfg_i.data[BYTE_W-1:0];
        REG_RL_ID:       motor_id_q[WHEEL_RL] <= cfg_i.data[BYTE_W-1:0];
        REG_RR_ID:       motor_id_q[WHEEL_RR] <= cfg_i.data[BYTE_W-1:0];
        REG_OPCODE:      opcode_q             <= cfg_i.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // magnitudes for the sign-magnitude multiply
  assign abs_wz  = in_i.yaw_rate[VEL_W-1] ? VEL_W'(-in_i.yaw_rate) : VEL_W'(in_i.yaw_rate);
  assign cur_tgt = targets_q[wheel_q];
  assign abs_tgt = cur_tgt[TGT_W-1] ? TGT_W'(-cur_tgt) : TGT_W'(cur_tgt);

  // yaw term, truncated toward zero by shifting the magnitude
  assign w_mag  = mul_prod[TWIST_SHIFT +: TGT_W];
  assign w_val  = neg_q ? TGT_W'(-w_mag) : TGT_W'(w_mag);
  assign vx_ext = {{(TGT_W - VEL_W){vel_x_q[VEL_W-1]}}, vel_x_q};
  assign vy_ext = {{(TGT_W - VEL_W){vel_y_q[VEL_W-1]}}, vel_y_q};

  // rpm scaling with saturation to int16
  assign rpm_mag = mul_prod[RPM_SHIFT +: RPM_MAG_W];

  always_comb begin
    if (!neg_q) begin
      rpm_sat = (rpm_mag > RPM_MAG_W'(RPM_POS_MAX)) ? RPM_POS_MAX : rpm_mag[RPM_W-1:0];
    end else if (rpm_mag > RPM_MAG_W'(RPM_NEG_MIN)) begin
      rpm_sat = RPM_NEG_MIN;
    end else begin
      rpm_sat = RPM_W'(~rpm_mag[RPM_W-1:0] + RPM_W'(1));
    end
  end

  // byte of the frame at the current position
  always_comb begin
    case (byte_idx_q)
      BYTE_ID:     cur_byte = motor_id_q[wheel_q];
      BYTE_OPCODE: cur_byte = opcode_q;
      BYTE_RPM_LO: cur_byte = rpm_q[BYTE_W-1:0];
      BYTE_RPM_HI: cur_byte = rpm_q[RPM_W-1:BYTE_W];
      BYTE_CRC:    cur_byte = crc_value;
      default:     cur_byte = BYTE_PAD;
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wheel_q    <= WHEEL_FL;
      byte_idx_q <= BYTE_ID;
      neg_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      wheel_q    <= wheel_d;
      byte_idx_q <= byte_idx_d;
      neg_q      <= neg_d;
    end
  end

  // sequencer next state and controls
  always_comb begin
    state_d    = state_q;
    wheel_d    = wheel_q;
    byte_idx_d = byte_idx_q;
    neg_d      = neg_q;
    in_ready   = 1'b0;
    twist_wr   = 1'b0;
    set_wr     = 1'b0;
    rpm_load   = 1'b0;
    out_load   = 1'b0;
    mul_start  = 1'b0;
    crc_ctrl   = '0;
    if (state_q == S_IDLE) begin
      mul_a = MUL_A_W'(abs_wz);
      mul_b = MUL_B_W'({1'b0, wheel_base_q} + {1'b0, track_width_q});
    end else begin
      mul_a = MUL_A_W'(abs_tgt);
      mul_b = MUL_B_W'(max_rpm_q);
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          case (in_i.cmd)
            CMD_TWIST: begin
              mul_start = 1'b1;
              neg_d     = in_i.yaw_rate[VEL_W-1];
              state_d   = S_TWIST_MUL;
            end
            CMD_SET: set_wr = 1'b1;
            CMD_SEND: begin
              wheel_d = WHEEL_FL;
              state_d = S_RPM_START;
            end
            default: ;
          endcase
        end
      end
      S_TWIST_MUL: begin
        if (mul_stat.done) begin
          twist_wr = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_RPM_START: begin
        mul_start      = 1'b1;
        neg_d          = cur_tgt[TGT_W-1];
        crc_ctrl.clear = 1'b1;
        byte_idx_d     = BYTE_ID;
        state_d        = S_RPM_MUL;
      end
      S_RPM_MUL: begin
        if (mul_stat.done) begin
          rpm_load = 1'b1;
          state_d  = S_BYTE;
        end
      end
      S_BYTE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (byte_idx_q == BYTE_CRC) begin
            if (wheel_q == WHEEL_RR) begin
              state_d = S_IDLE;
            end else begin
              wheel_d = wheel_q + WHEEL_W'(1);
              state_d = S_RPM_START;
            end
          end else begin
            crc_ctrl.start = 1'b1;
            state_d        = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (crc_stat.done) begin
          byte_idx_d = byte_idx_q + BIDX_W'(1);
          state_d    = S_BYTE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = in_ready;

  // wheel target store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WHEELS; i++) begin
        targets_q[i] <= '0;
      end
    end else if (twist_wr) begin
      targets_q[WHEEL_FL] <= vx_ext - vy_ext - w_val;
      targets_q[WHEEL_FR] <= vx_ext + vy_ext + w_val;
      targets_q[WHEEL_RL] <= vx_ext + vy_ext - w_val;
      targets_q[WHEEL_RR] <= vx_ext - vy_ext + w_val;
    end else if (set_wr) begin
      targets_q[in_i.wheel_sel] <= in_i.wheel_value;
    end
  end

  // held operands and rpm
  always_ff @(posedge clk_i) begin
    if (mul_start && state_q == S_IDLE) begin
      vel_x_q <= in_i.vel_x;
      vel_y_q <= in_i.vel_y;
    end
    if (rpm_load) begin
      rpm_q <= rpm_sat;
    end
  end

  // shared serial multiplier
  mwcf_sermul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  // frame crc
  mwcf_crc8 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (cur_byte),
    .stat_o (crc_stat),
    .crc_o  (crc_value)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q  <= cur_byte;
      out_wheel_q <= wheel_q;
      out_last_q  <= (wheel_q == WHEEL_RR) && (byte_idx_q == BYTE_CRC);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.frame_byte  = out_byte_q;
  assign out_o.wheel_index = out_wheel_q;
  assign out_o.last        = out_last_q;

  // checks
  `MWCF_ASSERT_IMP(a_last_on_rr, out_o.valid && out_o.last, out_o.wheel_index == WHEEL_RR, "burst end not on rear right wheel")
  `MWCF_ASSERT_NXT(a_send_start, in_i.valid && in_i.ready && in_i.cmd == CMD_SEND, state_q == S_RPM_START && wheel_q == WHEEL_FL, "send tick did not start at front left")
  `MWCF_ASSERT_IMP(a_mul_owner, mul_stat.busy, state_q == S_TWIST_MUL || state_q == S_RPM_MUL, "multiplier busy outside a multiply state")
  `MWCF_ASSERT_IMP(a_crc_owner, crc_stat.busy, state_q == S_CRC, "crc busy outside the crc state")

endmodule
